[src/ptt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes of the periodic timer table
// Function codes, status codes and the slot record layout.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam logic [2:0] FUNC_ONESHOT    = 3'd0;
	localparam logic [2:0] FUNC_PERIODIC   = 3'd1;
	localparam logic [2:0] FUNC_CANCEL     = 3'd2;
	localparam logic [2:0] FUNC_CANCEL_ALL = 3'd3;
	localparam logic [2:0] FUNC_TICK       = 3'd4;
	localparam logic [2:0] FUNC_QUERY      = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// most expiry results reported by one tick
	localparam int MAX_RESULTS = 16;

	localparam int SLOT_W = 32 + 32 + 30 + 1 + 1;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] remaining;
		logic [29:0] interval;
		logic        periodic;
		logic        cancelled;
	} slot_t;

endpackage
`default_nettype wire

[src/ptt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ram: generic single-port-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[src/periodic_timer_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_table_top: table of software timers in scheduling order
// Schedules, cancels, ticks and queries timers held in one slot RAM.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Schedule and the unused function codes
// register their result when they accept the transaction. Cancel, cancel all
// and query walk the used slots through the slot RAM, one slot per cycle, with
// registered read data. A tick walks the table twice: a first read-only pass
// counts the surviving timers and the expiries, so every result can carry the
// final live count and the last flag; the second pass updates, compacts and
// reports, and it stalls while a result waits on the output.
// ----------------------------------------------------------------------------
module periodic_timer_table_top
	import ptt_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  func,
	input  wire  [19:0] delay_ms,
	input  wire  [19:0] initial_delay_ms,
	input  wire  [31:0] task_id,
	input  wire  [23:0] elapsed_us,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  status,
	output logic [31:0] result_id,
	output logic        fired,
	output logic        pending,
	output logic [4:0]  live_count,
	output logic        last
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int RAM_D = 1 << AW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DONE  = 3'd2;
	localparam logic [2:0] S_COUNT = 3'd3;

	logic [2:0]    state_q;
	logic [2:0]    func_q;
	logic [31:0]   tid_q;
	logic [31:0]   elapsed_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] live_q;
	logic [31:0]   next_id_q;
	logic [CW-1:0] rd_q;     // next slot to read
	logic          vld_s1;   // read data valid
	logic [CW-1:0] idx_s1;   // slot index of read data
	logic [CW-1:0] wr_q;     // compaction write pointer
	logic          found_q;
	logic [CW-1:0] nf_q;     // expiries to report
	logic [CW-1:0] fcnt_q;   // expiries reported so far
	logic          stall;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	slot_t         ram_wdata;
	slot_t         ram_rdata;

	ptt_ram #(.WIDTH(SLOT_W), .DEPTH(RAM_D)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// per-slot evaluation of the read data
	slot_t       upd;
	logic [31:0] dec;
	logic        expire;
	logic        hit;
	always_comb begin
		upd    = ram_rdata;
		dec    = ram_rdata.remaining - elapsed_q;
		expire = 1'b0;
		hit    = (ram_rdata.id == tid_q);
		if (func_q == FUNC_TICK && !ram_rdata.cancelled) begin
			upd.remaining = dec;
			if ($signed(dec) <= 0) begin
				expire = 1'b1;
				if (ram_rdata.periodic) begin
					upd.remaining = {2'b00, ram_rdata.interval};
				end else begin
					upd.cancelled = 1'b1;
				end
			end
		end
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign stall    = out_valid && !out_ready;

	// re-read the held slot while the output stalls
	assign ram_raddr = stall ? idx_s1[AW-1:0] : rd_q[AW-1:0];

	// slot RAM write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1[AW-1:0];
		ram_wdata = upd;
		if (state_q == S_IDLE && in_valid && in_ready &&
		    (func == FUNC_ONESHOT || func == FUNC_PERIODIC) && used_q < CW'(MAX_TASKS)) begin
			ram_we              = 1'b1;
			ram_waddr           = used_q[AW-1:0];
			ram_wdata.id        = next_id_q;
			ram_wdata.periodic  = (func == FUNC_PERIODIC);
			ram_wdata.cancelled = 1'b0;
			ram_wdata.interval  = (func == FUNC_PERIODIC) ? 30'(delay_ms * 30'd1000) : 30'd0;
			ram_wdata.remaining = (func == FUNC_PERIODIC && initial_delay_ms != 20'd0) ?
			                      32'(initial_delay_ms * 30'd1000) :
			                      32'(delay_ms * 30'd1000);
		end else if (state_q == S_SCAN && vld_s1 && !stall) begin
			unique case (func_q)
				FUNC_CANCEL: begin
					ram_we              = hit && !found_q;
					ram_wdata.cancelled = 1'b1;
				end
				FUNC_CANCEL_ALL: begin
					ram_we        = 1'b1;
					ram_wdata.cancelled = 1'b1;
				end
				FUNC_TICK: begin
					ram_we    = !upd.cancelled;
					ram_waddr = wr_q[AW-1:0];
				end
				default: ram_we = 1'b0;
			endcase
		end
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			live_q    <= '0;
			next_id_q <= 32'd1;
			out_valid <= 1'b0;
			vld_s1    <= 1'b0;
			rd_q      <= '0;
			idx_s1    <= '0;
			wr_q      <= '0;
			found_q   <= 1'b0;
			nf_q      <= '0;
			fcnt_q    <= '0;
			func_q    <= '0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						func_q    <= func;
						tid_q     <= task_id;
						elapsed_q <= {8'd0, elapsed_us};
						rd_q      <= '0;
						vld_s1    <= 1'b0;
						wr_q      <= '0;
						found_q   <= 1'b0;
						nf_q      <= '0;
						fcnt_q    <= '0;
						status    <= ST_OK;
						result_id <= 32'd0;
						fired     <= 1'b0;
						pending   <= 1'b0;
						last      <= 1'b1;
						if (func == FUNC_ONESHOT || func == FUNC_PERIODIC) begin
							if (used_q < CW'(MAX_TASKS)) begin
								result_id  <= next_id_q;
								next_id_q  <= next_id_q + 32'd1;
								used_q     <= used_q + CW'(1);
								live_q     <= live_q + CW'(1);
								live_count <= 5'(live_q + CW'(1));
							end else begin
								status     <= ST_FULL;
								live_count <= 5'(live_q);
							end
							out_valid <= 1'b1;
						end else if (func == FUNC_TICK) begin
							state_q <= S_COUNT;
							live_q  <= '0;
						end else if (func == FUNC_CANCEL || func == FUNC_CANCEL_ALL ||
						             func == FUNC_QUERY) begin
							state_q <= S_SCAN;
						end else begin
							live_count <= 5'(live_q);
							out_valid  <= 1'b1;
						end
					end
				end
				S_COUNT: begin
					// first tick pass: count survivors and expiries, write nothing
					if (rd_q < used_q) begin
						rd_q   <= rd_q + CW'(1);
						vld_s1 <= 1'b1;
						idx_s1 <= rd_q;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if (!upd.cancelled) begin
							live_q <= live_q + CW'(1);
						end
						if (expire) begin
							nf_q <= nf_q + CW'(1);
						end
					end
					if (!(rd_q < used_q) && !vld_s1) begin
						state_q <= S_SCAN;
						rd_q    <= '0;
						// expiries beyond the report limit stay silent
						if (MAX_TASKS > MAX_RESULTS && nf_q > CW'(MAX_RESULTS)) begin
							nf_q <= CW'(MAX_RESULTS);
						end
					end
				end
				S_SCAN: begin
					if (!stall) begin
						// issue next read
						if (rd_q < used_q) begin
							rd_q   <= rd_q + CW'(1);
							vld_s1 <= 1'b1;
							idx_s1 <= rd_q;
						end else begin
							vld_s1 <= 1'b0;
						end
						// consume read data
						if (vld_s1) begin
							unique case (func_q)
								FUNC_CANCEL: begin
									if (hit && !found_q) begin
										found_q <= 1'b1;
										if (!ram_rdata.cancelled) begin
											live_q <= live_q - CW'(1);
										end
									end
								end
								FUNC_QUERY: begin
									if (hit && !ram_rdata.cancelled) begin
										found_q <= 1'b1;
									end
								end
								FUNC_TICK: begin
									if (!upd.cancelled) begin
										wr_q <= wr_q + CW'(1);
									end
									if (expire && fcnt_q < nf_q) begin
										fcnt_q    <= fcnt_q + CW'(1);
										out_valid <= 1'b1;
										status    <= ST_OK;
										result_id <= ram_rdata.id;
										fired     <= 1'b1;
										pending   <= 1'b0;
										last      <= (fcnt_q + CW'(1) == nf_q);
										live_count <= 5'(live_q);
									end
								end
								default: begin
								end
							endcase
						end
						if (!(rd_q < used_q) && !vld_s1) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!stall) begin
						state_q <= S_IDLE;
						if (func_q == FUNC_TICK) begin
							used_q <= wr_q;
						end
						// expiry results of a tick are already out
						if (func_q != FUNC_TICK || nf_q == '0) begin
							out_valid <= 1'b1;
							last      <= 1'b1;
							fired     <= 1'b0;
							pending   <= 1'b0;
							status    <= ST_OK;
							result_id <= 32'd0;
							live_count <= 5'(live_q);
							unique case (func_q)
								FUNC_CANCEL: begin
									status    <= found_q ? ST_OK : ST_NOT_FOUND;
									result_id <= tid_q;
								end
								FUNC_QUERY: begin
									status    <= found_q ? ST_OK : ST_NOT_FOUND;
									pending   <= found_q;
									result_id <= tid_q;
								end
								FUNC_CANCEL_ALL: begin
									live_q     <= '0;
									live_count <= 5'd0;
								end
								default: begin
								end
							endcase
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/ptt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_checker: port-level checks of the periodic timer table
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module ptt_checker
	import ptt_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [1:0]  status,
	input wire [31:0] result_id,
	input wire        fired,
	input wire        pending,
	input wire        last
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_id) && $stable(last))
		else $error("stalled result changed");

	// no new transaction while a result waits
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted with result pending");

	// fired and pending exclusive
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fired && pending))
		else $error("fired and pending together");

	// pending only with ok status
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pending |-> status == ST_OK)
		else $error("pending with error status");

	// hold an offered transaction until it is taken
	a_inhold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("offered transaction dropped");

endmodule

bind periodic_timer_table_top ptt_checker u_ptt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.result_id (result_id),
	.fired     (fired),
	.pending   (pending),
	.last      (last)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking regression of the periodic timer table
// Feeds schedule, cancel, tick and query transactions through valid/ready,
// predicts every result from a private copy of the timer table and compares
// each result transaction field by field, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb
	import ptt_pkg::*;
();

	localparam int TASKS       = 16;
	localparam int RAND_ITEMS  = 350;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] FUNC_SPARE6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE7 = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [19:0] delay;
		logic [19:0] init;
		logic [31:0] tid;
		logic [23:0] elapsed;
	} timer_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] id;
		logic        fired;
		logic        pending;
		logic [4:0]  live;
		logic        last;
	} timer_evt_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [2:0]  func = '0;
	logic [19:0] delay_ms = '0;
	logic [19:0] initial_delay_ms = '0;
	logic [31:0] task_id = '0;
	logic [23:0] elapsed_us = '0;
	logic        out_ready = 1'b0;
	logic        hold_off = 1'b0;
	wire         in_ready;
	wire         out_valid;
	wire  [1:0]  status;
	wire  [31:0] result_id;
	wire         fired;
	wire         pending;
	wire  [4:0]  live_count;
	wire         last;

	timer_cmd_t cmd_q[$];
	timer_evt_t evt_q[$];
	int unsigned accepted = 0;
	int unsigned cycles = 0;
	int unsigned errors = 0;

	// private copy of the timer table
	logic [31:0]        t_id[TASKS];
	logic signed [31:0] t_rem[TASKS];
	logic [31:0]        t_ivl[TASKS];
	logic               t_per[TASKS];
	logic               t_can[TASKS];
	int                 t_used = 0;
	logic [31:0]        t_next = 32'd1;

	periodic_timer_table_top #(.MAX_TASKS(TASKS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .delay_ms(delay_ms), .initial_delay_ms(initial_delay_ms),
		.task_id(task_id), .elapsed_us(elapsed_us),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_id(result_id), .fired(fired),
		.pending(pending), .live_count(live_count), .last(last)
	);

	initial forever #5 clk = ~clk;

	// append to the pending command and expected result queues
	task automatic add_cmd(timer_cmd_t c);
		cmd_q.insert(cmd_q.size(), c);
	endtask

	task automatic add_evt(timer_evt_t e);
		evt_q.insert(evt_q.size(), e);
	endtask

	function automatic logic [4:0] live_timers();
		int n;
		n = 0;
		for (int i = 0; i < t_used; i++)
			if (!t_can[i])
				n++;
		return n[4:0];
	endfunction

	function automatic timer_evt_t make_evt(logic [1:0] st, logic [31:0] id,
		logic fi, logic pe, logic la);
		timer_evt_t e;
		e.status = st;
		e.id = id;
		e.fired = fi;
		e.pending = pe;
		e.live = live_timers();
		e.last = la;
		return e;
	endfunction

	// expected results of one accepted transaction
	task automatic timer_table_predict(timer_cmd_t c);
		logic [31:0] dly;
		logic [31:0] ini;
		logic [31:0] fid[TASKS];
		logic [1:0]  st;
		logic [31:0] id;
		logic        pend;
		int          nf;
		int          w;
		dly = {12'd0, c.delay} * 32'd1000;
		ini = {12'd0, c.init} * 32'd1000;
		st = ST_OK;
		id = '0;
		case (c.func)
			FUNC_ONESHOT, FUNC_PERIODIC: begin
				if (t_used >= TASKS) begin
					st = ST_FULL;
				end else begin
					id = t_next;
					t_next = t_next + 32'd1;
					t_id[t_used] = id;
					t_per[t_used] = (c.func == FUNC_PERIODIC);
					t_can[t_used] = 1'b0;
					t_ivl[t_used] = (c.func == FUNC_PERIODIC) ? dly : 32'd0;
					t_rem[t_used] = (c.func == FUNC_PERIODIC && ini != 0) ? ini : dly;
					t_used++;
				end
				add_evt(make_evt(st, id, 1'b0, 1'b0, 1'b1));
			end
			FUNC_CANCEL: begin
				st = ST_NOT_FOUND;
				for (int i = 0; i < t_used; i++)
					if (st == ST_NOT_FOUND && t_id[i] == c.tid) begin
						t_can[i] = 1'b1;
						st = ST_OK;
					end
				add_evt(make_evt(st, c.tid, 1'b0, 1'b0, 1'b1));
			end
			FUNC_CANCEL_ALL: begin
				for (int i = 0; i < t_used; i++)
					t_can[i] = 1'b1;
				add_evt(make_evt(ST_OK, '0, 1'b0, 1'b0, 1'b1));
			end
			FUNC_QUERY: begin
				pend = 1'b0;
				for (int i = 0; i < t_used; i++)
					if (t_id[i] == c.tid && !t_can[i])
						pend = 1'b1;
				add_evt(make_evt(pend ? ST_OK : ST_NOT_FOUND, c.tid,
					1'b0, pend, 1'b1));
			end
			FUNC_TICK: begin
				nf = 0;
				for (int i = 0; i < t_used; i++) begin
					if (!t_can[i]) begin
						t_rem[i] = t_rem[i] - $signed({8'd0, c.elapsed});
						if (t_rem[i] <= 0) begin
							fid[nf] = t_id[i];
							nf++;
							if (t_per[i])
								t_rem[i] = t_ivl[i];
							else
								t_can[i] = 1'b1;
						end
					end
				end
				// drop fired one-shots and cancelled slots, keep order
				w = 0;
				for (int i = 0; i < t_used; i++) begin
					if (!t_can[i]) begin
						t_id[w] = t_id[i];
						t_rem[w] = t_rem[i];
						t_ivl[w] = t_ivl[i];
						t_per[w] = t_per[i];
						t_can[w] = 1'b0;
						w++;
					end
				end
				t_used = w;
				if (nf == 0)
					add_evt(make_evt(ST_OK, '0, 1'b0, 1'b0, 1'b1));
				for (int n = 0; n < nf; n++)
					add_evt(make_evt(ST_OK, fid[n], 1'b1, 1'b0, n == nf - 1));
			end
			default: begin
				add_evt(make_evt(ST_OK, '0, 1'b0, 1'b0, 1'b1));
			end
		endcase
	endtask

	function automatic timer_cmd_t mk_cmd(logic [2:0] f, logic [19:0] d, logic [19:0] i,
		logic [31:0] t, logic [23:0] e);
		timer_cmd_t c;
		c.func = f;
		c.delay = d;
		c.init = i;
		c.tid = t;
		c.elapsed = e;
		return c;
	endfunction

	function automatic logic [19:0] rand_ms();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 20'($urandom_range(0, 20));
		else if (r < 90)
			return 20'($urandom_range(0, 1000));
		return 20'($urandom);
	endfunction

	function automatic logic [23:0] rand_elapsed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 24'($urandom_range(0, 20000));
		else if (r < 90)
			return 24'($urandom_range(0, 2000000));
		return 24'($urandom);
	endfunction

	// idle mixes: none, sender, receiver, both
	function automatic int send_idle_pct();
		case (accepted / 95)
			0: return 0;
			1: return 57;
			2: return 0;
			default: return 10;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case (accepted / 95)
			0, 1: return 0;
			2: return 57;
			default: return 10;
		endcase
	endfunction

	// stimulus: directed corners, then random traffic
	initial begin
		int unsigned sched;
		int r;
		logic [2:0] f;
		sched = 0;
		add_cmd(mk_cmd(FUNC_ONESHOT, 20'd0, 20'hFFFFF, 32'hFFFFFFFF, 24'hFFFFFF));
		add_cmd(mk_cmd(FUNC_PERIODIC, 20'd0, 20'd0, '0, '0));
		add_cmd(mk_cmd(FUNC_PERIODIC, 20'd5, 20'd2, '0, '0));
		add_cmd(mk_cmd(FUNC_ONESHOT, 20'hFFFFF, 20'd0, '0, '0));
		add_cmd(mk_cmd(FUNC_QUERY, '0, '0, 32'd4, '0));
		add_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, 24'd0));
		add_cmd(mk_cmd(FUNC_QUERY, '0, '0, 32'd1, '0));
		add_cmd(mk_cmd(FUNC_CANCEL, '0, '0, 32'd4, '0));
		add_cmd(mk_cmd(FUNC_CANCEL, '0, '0, 32'd4, '0));
		add_cmd(mk_cmd(FUNC_QUERY, '0, '0, 32'd4, '0));
		add_cmd(mk_cmd(FUNC_CANCEL, '0, '0, 32'hFFFFFFFF, '0));
		add_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, 24'd2000));
		add_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, 24'hFFFFFF));
		add_cmd(mk_cmd(FUNC_SPARE6, 20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 24'hFFFFFF));
		add_cmd(mk_cmd(FUNC_SPARE7, '0, '0, '0, '0));
		add_cmd(mk_cmd(FUNC_CANCEL_ALL, '0, '0, '0, '0));
		add_cmd(mk_cmd(FUNC_QUERY, '0, '0, 32'd2, '0));
		add_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, 24'd1));
		sched = 4;
		while (cmd_q.size() < 18 + RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				// burst past a full table, then a tick that fires many
				for (int k = 0; k < TASKS + 1; k++) begin
					f = $urandom_range(0, 1) ? FUNC_PERIODIC : FUNC_ONESHOT;
					add_cmd(mk_cmd(f, 20'($urandom_range(0, 3)), 20'($urandom_range(0, 1)),
						$urandom, 24'($urandom)));
				end
				sched += TASKS;
				add_cmd(mk_cmd(FUNC_TICK, 20'($urandom), 20'($urandom), $urandom, 24'd4000));
			end else if (r < 30) begin
				add_cmd(mk_cmd(FUNC_ONESHOT, rand_ms(), 20'($urandom), $urandom,
					24'($urandom)));
				sched++;
			end else if (r < 50) begin
				add_cmd(mk_cmd(FUNC_PERIODIC, rand_ms(),
					$urandom_range(0, 1) ? 20'd0 : rand_ms(), $urandom, 24'($urandom)));
				sched++;
			end else if (r < 75) begin
				add_cmd(mk_cmd(FUNC_TICK, 20'($urandom), 20'($urandom), $urandom,
					rand_elapsed()));
			end else if (r < 97) begin
				f = (r < 87) ? FUNC_CANCEL : FUNC_QUERY;
				add_cmd(mk_cmd(f, 20'($urandom), 20'($urandom),
					$urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, sched + 2),
					24'($urandom)));
			end else if (r < 99) begin
				add_cmd(mk_cmd(FUNC_CANCEL_ALL, 20'($urandom), 20'($urandom), $urandom,
					24'($urandom)));
			end else begin
				f = $urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7;
				add_cmd(mk_cmd(f, 20'($urandom), 20'($urandom), $urandom, 24'($urandom)));
			end
		end
	end

	// reset, then wait for drain and report
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (cmd_q.size() != 0 || in_valid || evt_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && evt_q.size() == 0)
			$display("periodic_timer_table_top regression: pass");
		else
			$display("periodic_timer_table_top regression: fail");
		$finish;
	end

	// long receiver hold-off so the block backs up its input
	initial begin
		wait (accepted >= 200);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// driver: offer pending commands, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				timer_table_predict(mk_cmd(func, delay_ms, initial_delay_ms, task_id, elapsed_us));
				accepted <= accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
					timer_cmd_t c;
					c = cmd_q.pop_front();
					in_valid <= 1'b1;
					func <= c.func;
					delay_ms <= c.delay;
					initial_delay_ms <= c.init;
					task_id <= c.tid;
					elapsed_us <= c.elapsed;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct());
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (evt_q.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10)
					$display("unexpected result: status=%0d id=%h fired=%b", status,
						result_id, fired);
			end else begin
				timer_evt_t e;
				e = evt_q.pop_front();
				if (e != {status, result_id, fired, pending, live_count, last}) begin
					errors <= errors + 1;
					if (errors < 10)
						$display({"mismatch: exp st=%0d id=%h f=%b p=%b live=%0d last=%b",
							" / got st=%0d id=%h f=%b p=%b live=%0d last=%b"},
							e.status, e.id, e.fired, e.pending, e.live, e.last,
							status, result_id, fired, pending, live_count, last);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("periodic_timer_table_top regression: fail");
			$finish;
		end
	end

endmodule

[sim.f]
src/ptt_pkg.sv
src/ptt_ram.sv
src/periodic_timer_table_top.sv
src/ptt_checker.sv
tb/tb.sv
